### rtl/core/fkr_pkg.sv
// fkr_pkg: shared types and constants for the keyed-removal queue
// no dependencies; used by the interfaces, fkr_store, fkr_seq and the top level
`timescale 1ns / 1ps
`default_nettype none

package fkr_pkg;

	localparam int DEPTH        = 16;
	localparam int KEY_BITS     = 16;
	localparam int PAYLOAD_BITS = 32;
	localparam int FILL_BITS    = 5;
	localparam int IDX_BITS     = $clog2(DEPTH);
	localparam int CNT_BITS     = $clog2(DEPTH + 1);

	typedef logic [IDX_BITS-1:0]     idx_t;
	typedef logic [CNT_BITS-1:0]     cnt_t;
	typedef logic [KEY_BITS-1:0]     key_t;
	typedef logic [PAYLOAD_BITS-1:0] payload_t;
	typedef logic [FILL_BITS-1:0]    fill_t;

	// operation codes carried in the kind field
	typedef enum logic [1:0] {
		KIND_INSERT   = 2'd0,
		KIND_DELETE   = 2'd1,
		KIND_TRAVERSE = 2'd2,
		KIND_CLEAR    = 2'd3
	} kind_t;

	// one stored entry
	typedef struct packed {
		key_t     key;
		payload_t payload;
	} entry_t;

	// access request from the sequencer to the entry memory
	typedef struct packed {
		logic   we;
		idx_t   waddr;
		entry_t wdata;
		logic   re;
		idx_t   raddr;
	} mem_req_t;

	// result beat held in the output register
	typedef struct packed {
		logic     ok;
		key_t     out_key;
		payload_t out_payload;
		fill_t    fill_count;
		logic     last;
	} rsp_beat_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TRV_RD,
		ST_TRV_DAT,
		ST_DEL_RD,
		ST_DEL_CMP,
		ST_SH_RD,
		ST_SH_WR,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

### rtl/core/fkr_if.sv
// fkr_cmd_if and fkr_rsp_if: valid/ready channels for command and result beats
// depends on fkr_pkg
`timescale 1ns / 1ps
`default_nettype none

interface fkr_cmd_if;
	logic              valid;
	logic              ready;
	fkr_pkg::kind_t    kind;
	fkr_pkg::key_t     entry_key;
	fkr_pkg::payload_t entry_payload;

	modport source (output valid, output kind, output entry_key, output entry_payload,
		input ready);
	modport sink (input valid, input kind, input entry_key, input entry_payload,
		output ready);
endinterface

interface fkr_rsp_if;
	logic              valid;
	logic              ready;
	logic              ok;
	fkr_pkg::key_t     out_key;
	fkr_pkg::payload_t out_payload;
	fkr_pkg::fill_t    fill_count;
	logic              last;

	modport source (output valid, output ok, output out_key, output out_payload,
		output fill_count, output last, input ready);
	modport sink (input valid, input ok, input out_key, input out_payload,
		input fill_count, input last, output ready);
endinterface

`default_nettype wire

### rtl/core/fkr_store.sv
// fkr_store: entry memory, one write port and one read port, registered read data
// depends on fkr_pkg
`timescale 1ns / 1ps
`default_nettype none

module fkr_store (
	input  wire logic              clk,
	input  wire fkr_pkg::mem_req_t req,
	output fkr_pkg::entry_t        rdata
);

	fkr_pkg::entry_t mem_q [fkr_pkg::DEPTH];
	fkr_pkg::entry_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	// read port, read data registered and valid in the cycle after the request
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/core/fkr_seq.sv
// fkr_seq: operation sequencer with fill count, search, compaction and result register
// depends on fkr_pkg and the fkr_cmd_if / fkr_rsp_if interfaces
`timescale 1ns / 1ps
`default_nettype none

module fkr_seq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	fkr_cmd_if.sink                cmd,
	fkr_rsp_if.source              rsp,
	output fkr_pkg::mem_req_t      mem_req,
	input  wire fkr_pkg::entry_t   rdata
);

	fkr_pkg::state_t    state_q, state_d;
	fkr_pkg::idx_t      idx_q;
	fkr_pkg::cnt_t      count_q;
	fkr_pkg::key_t      key_q;
	fkr_pkg::kind_t     kind_q;
	fkr_pkg::rsp_beat_t out_q;
	fkr_pkg::rsp_beat_t out_d;

	logic cmd_beat;
	logic rsp_beat;
	logic at_last;
	logic is_full;
	logic is_empty;
	logic key_hit;

	assign cmd_beat = cmd.valid && cmd.ready;
	assign rsp_beat = rsp.valid && rsp.ready;
	assign at_last  = (fkr_pkg::CNT_BITS'(idx_q) + fkr_pkg::CNT_BITS'(1)) == count_q;
	assign is_full  = count_q == fkr_pkg::CNT_BITS'(fkr_pkg::DEPTH);
	assign is_empty = count_q == '0;
	assign key_hit  = rdata.key == key_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fkr_pkg::ST_IDLE: begin
				if (cmd_beat) begin
					unique case (cmd.kind)
						fkr_pkg::KIND_TRAVERSE: state_d = is_empty ? fkr_pkg::ST_OUT
							: fkr_pkg::ST_TRV_RD;
						fkr_pkg::KIND_DELETE: state_d = is_empty ? fkr_pkg::ST_OUT
							: fkr_pkg::ST_DEL_RD;
						fkr_pkg::KIND_INSERT,
						fkr_pkg::KIND_CLEAR: state_d = fkr_pkg::ST_OUT;
					endcase
				end
			end
			fkr_pkg::ST_TRV_RD:  state_d = fkr_pkg::ST_TRV_DAT;
			fkr_pkg::ST_TRV_DAT: state_d = fkr_pkg::ST_OUT;
			fkr_pkg::ST_DEL_RD:  state_d = fkr_pkg::ST_DEL_CMP;
			fkr_pkg::ST_DEL_CMP: begin
				priority if (key_hit) begin
					state_d = fkr_pkg::ST_SH_RD;
				end else if (at_last) begin
					state_d = fkr_pkg::ST_OUT;
				end else begin
					state_d = fkr_pkg::ST_DEL_RD;
				end
			end
			fkr_pkg::ST_SH_RD: state_d = at_last ? fkr_pkg::ST_OUT : fkr_pkg::ST_SH_WR;
			fkr_pkg::ST_SH_WR: state_d = fkr_pkg::ST_SH_RD;
			fkr_pkg::ST_OUT: begin
				if (rsp_beat) begin
					if (kind_q == fkr_pkg::KIND_TRAVERSE && !out_q.last) begin
						state_d = fkr_pkg::ST_TRV_RD;
					end else begin
						state_d = fkr_pkg::ST_IDLE;
					end
				end
			end
		endcase
	end

	// handshake and memory access
	always_comb begin
		cmd.ready     = 1'b0;
		rsp.valid     = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.waddr = idx_q;
		mem_req.wdata = rdata;
		mem_req.re    = 1'b0;
		mem_req.raddr = idx_q;
		unique case (state_q)
			fkr_pkg::ST_IDLE: begin
				cmd.ready     = 1'b1;
				mem_req.waddr = count_q[fkr_pkg::IDX_BITS-1:0];
				mem_req.wdata = '{key: cmd.entry_key, payload: cmd.entry_payload};
				mem_req.we    = cmd.valid && cmd.kind == fkr_pkg::KIND_INSERT && !is_full;
			end
			fkr_pkg::ST_TRV_RD,
			fkr_pkg::ST_DEL_RD: begin
				mem_req.re = 1'b1;
			end
			fkr_pkg::ST_SH_RD: begin
				mem_req.re    = !at_last;
				mem_req.raddr = idx_q + fkr_pkg::IDX_BITS'(1);
			end
			fkr_pkg::ST_SH_WR: begin
				mem_req.we = 1'b1;
			end
			fkr_pkg::ST_OUT: begin
				rsp.valid = 1'b1;
			end
			fkr_pkg::ST_TRV_DAT,
			fkr_pkg::ST_DEL_CMP: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fkr_pkg::ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				fkr_pkg::ST_IDLE: begin
					idx_q <= '0;
					if (cmd_beat) begin
						if (cmd.kind == fkr_pkg::KIND_INSERT && !is_full) begin
							count_q <= count_q + fkr_pkg::CNT_BITS'(1);
						end
						if (cmd.kind == fkr_pkg::KIND_CLEAR) begin
							count_q <= '0;
						end
					end
				end
				fkr_pkg::ST_DEL_CMP: begin
					if (!key_hit && !at_last) begin
						idx_q <= idx_q + fkr_pkg::IDX_BITS'(1);
					end
				end
				fkr_pkg::ST_SH_RD: begin
					if (at_last) begin
						count_q <= count_q - fkr_pkg::CNT_BITS'(1);
					end
				end
				fkr_pkg::ST_SH_WR: begin
					idx_q <= idx_q + fkr_pkg::IDX_BITS'(1);
				end
				fkr_pkg::ST_OUT: begin
					if (rsp_beat && !out_q.last) begin
						idx_q <= idx_q + fkr_pkg::IDX_BITS'(1);
					end
				end
				fkr_pkg::ST_TRV_RD,
				fkr_pkg::ST_TRV_DAT,
				fkr_pkg::ST_DEL_RD: begin
				end
			endcase
		end
	end

	// next result beat
	always_comb begin
		out_d = out_q;
		unique case (state_q)
			fkr_pkg::ST_IDLE: begin
				if (cmd_beat) begin
					out_d      = '0;
					out_d.last = 1'b1;
					unique case (cmd.kind)
						fkr_pkg::KIND_INSERT: begin
							out_d.ok         = !is_full;
							out_d.fill_count = is_full ? fkr_pkg::FILL_BITS'(count_q)
								: fkr_pkg::FILL_BITS'(count_q + fkr_pkg::CNT_BITS'(1));
						end
						fkr_pkg::KIND_CLEAR: begin
							out_d.ok = 1'b1;
						end
						fkr_pkg::KIND_DELETE,
						fkr_pkg::KIND_TRAVERSE: begin
							out_d.fill_count = fkr_pkg::FILL_BITS'(count_q);
						end
					endcase
				end
			end
			fkr_pkg::ST_TRV_DAT: begin
				out_d.ok          = 1'b1;
				out_d.out_key     = rdata.key;
				out_d.out_payload = rdata.payload;
				out_d.fill_count  = fkr_pkg::FILL_BITS'(count_q);
				out_d.last        = at_last;
			end
			fkr_pkg::ST_DEL_CMP: begin
				if (key_hit) begin
					out_d.ok          = 1'b1;
					out_d.out_key     = rdata.key;
					out_d.out_payload = rdata.payload;
				end
			end
			fkr_pkg::ST_SH_RD: begin
				if (at_last) begin
					out_d.fill_count = fkr_pkg::FILL_BITS'(count_q - fkr_pkg::CNT_BITS'(1));
				end
			end
			fkr_pkg::ST_TRV_RD,
			fkr_pkg::ST_DEL_RD,
			fkr_pkg::ST_SH_WR,
			fkr_pkg::ST_OUT: begin
			end
		endcase
	end

	// result register and operation context
	always_ff @(posedge clk) begin
		if (state_q == fkr_pkg::ST_IDLE && cmd_beat) begin
			kind_q <= cmd.kind;
			key_q  <= cmd.entry_key;
		end
		out_q <= out_d;
	end

	// result beat to the port
	assign rsp.ok          = out_q.ok;
	assign rsp.out_key     = out_q.out_key;
	assign rsp.out_payload = out_q.out_payload;
	assign rsp.fill_count  = out_q.fill_count;
	assign rsp.last        = out_q.last;

	// fill count stays within capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fkr_pkg::CNT_BITS'(fkr_pkg::DEPTH))
		else $error("fill count above capacity");

	// writes only land at or below the tail
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> fkr_pkg::CNT_BITS'(mem_req.waddr) <= count_q)
		else $error("memory write beyond tail");

	// end of compaction removes exactly one entry
	a_delete_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fkr_pkg::ST_SH_RD && at_last) |=>
		count_q == $past(count_q) - fkr_pkg::CNT_BITS'(1))
		else $error("delete did not shrink the queue by one");

	// a traverse beat flagged last comes from the tail entry
	a_trav_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fkr_pkg::ST_OUT && kind_q == fkr_pkg::KIND_TRAVERSE &&
		out_q.ok && out_q.last) |-> at_last)
		else $error("traverse ended before the tail");

endmodule

`default_nettype wire

### rtl/core/fifo_with_keyed_removal.sv
// Insert, clear and a delete on an empty queue offer their result beat in the cycle after
// the command beat. A delete reads and compares each entry searched (ST_DEL_RD, ST_DEL_CMP),
// then moves each later entry up (ST_SH_RD, ST_SH_WR); traverse gives one beat per entry
// through ST_TRV_RD, ST_TRV_DAT and ST_OUT. Throughput: one operation at a time, as the
// sequencer takes a command only in ST_IDLE. Reset: arst_n clears the fill count and the
// sequencer; the memory is not cleared. Top level: sequencer plus entry memory
`timescale 1ns / 1ps
`default_nettype none

module fifo_with_keyed_removal (
	input  wire logic clk,
	input  wire logic arst_n,
	fkr_cmd_if.sink   cmd,
	fkr_rsp_if.source rsp
);

	fkr_pkg::mem_req_t mem_req;
	fkr_pkg::entry_t   rdata;

	// operation sequencer
	fkr_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rsp     (rsp),
		.mem_req (mem_req),
		.rdata   (rdata)
	);

	// entry memory
	fkr_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

endmodule

`default_nettype wire
